// ===== rtl/core/skbt_pkg.sv =====
// ---------------------------------------------------------------------------
// skbt_pkg
// Shared widths, operation and status codes, sequencer states and the
// control bundles of the sorted key balance table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package skbt_pkg;

  localparam int unsigned MaxEntries = 128;

  localparam int unsigned KindW = 2;
  localparam int unsigned KeyW  = 32;
  localparam int unsigned AmtW  = 48;
  localparam int unsigned StatW = 2;
  localparam int unsigned PosW  = 7;

  // operation codes
  localparam logic [KindW-1:0] KIND_ADD      = 2'd0;
  localparam logic [KindW-1:0] KIND_DEPOSIT  = 2'd1;
  localparam logic [KindW-1:0] KIND_WITHDRAW = 2'd2;
  localparam logic [KindW-1:0] KIND_QUERY    = 2'd3;

  // result status codes
  localparam logic [StatW-1:0] STAT_OK        = 2'd0;
  localparam logic [StatW-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [StatW-1:0] STAT_FULL      = 2'd2;
  localparam logic [StatW-1:0] STAT_REFUSED   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_PROBE,
    ST_CMP,
    ST_BAL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic init;  // load search bounds
    logic rd;    // read key at midpoint
    logic cmp;   // narrow bounds after a non-matching probe
    logic wr;    // append key
  } srch_ctrl_t;

  typedef struct packed {
    logic miss;  // search range empty
    logic hit;   // probed key equals request key
  } srch_stat_t;

  typedef struct packed {
    logic rd;      // read balance of found slot
    logic upd;     // add/sub and write back
    logic wr_new;  // append starting balance
  } ledg_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/skbt_if.sv =====
// ---------------------------------------------------------------------------
// skbt_req_if / skbt_rsp_if
// Valid/ready channels carrying table requests and their results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface skbt_req_if;
  logic                           valid;
  logic                           ready;
  logic [skbt_pkg::KindW-1:0]     kind;
  logic [skbt_pkg::KeyW-1:0]      key;
  logic [skbt_pkg::AmtW-1:0]      amount;

  modport source (output valid, kind, key, amount, input ready);
  modport sink   (input valid, kind, key, amount, output ready);
endinterface

interface skbt_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [skbt_pkg::StatW-1:0]     status;
  logic [skbt_pkg::PosW-1:0]      position;
  logic [skbt_pkg::AmtW-1:0]      balance;

  modport source (output valid, status, position, balance, input ready);
  modport sink   (input valid, status, position, balance, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/skbt_search.sv =====
// ---------------------------------------------------------------------------
// skbt_search
// Key memory with compare logic that is stepped through a binary
// search, one midpoint read and one compare per probe.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module skbt_search #(
  parameter int unsigned MAX_ENTRIES = skbt_pkg::MaxEntries,
  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1),
  localparam int unsigned IdxW = $clog2(MAX_ENTRIES)
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire skbt_pkg::srch_ctrl_t      ctrl_i,
  input  wire logic [CntW-1:0]           count_i,
  input  wire logic [skbt_pkg::KeyW-1:0] key_i,
  output skbt_pkg::srch_stat_t           stat_o,
  output logic [IdxW-1:0]                slot_o
);

  logic [skbt_pkg::KeyW-1:0] key_mem [MAX_ENTRIES];
  logic [skbt_pkg::KeyW-1:0] probe_q;

  // bounds: lo inclusive, hi exclusive
  logic [CntW-1:0] lo_q, lo_d;
  logic [CntW-1:0] hix_q, hix_d;
  logic [IdxW-1:0] mid_q;
  logic [CntW:0]   span;
  logic [IdxW-1:0] mid;

  assign span = {1'b0, lo_q} + {1'b0, hix_q} - (CntW + 1)'(1);
  assign mid  = span[IdxW:1];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      key_mem[count_i[IdxW-1:0]] <= key_i;
    end
    if (ctrl_i.rd) begin
      probe_q <= key_mem[mid];
    end
  end

  always_comb begin
    lo_d  = lo_q;
    hix_d = hix_q;
    if (ctrl_i.init) begin
      lo_d  = '0;
      hix_d = count_i;
    end else if (ctrl_i.cmp) begin
      if (probe_q < key_i) begin
        lo_d = CntW'(mid_q) + CntW'(1);
      end else begin
        hix_d = CntW'(mid_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q  <= '0;
      hix_q <= '0;
      mid_q <= '0;
    end else begin
      lo_q  <= lo_d;
      hix_q <= hix_d;
      if (ctrl_i.rd) begin
        mid_q <= mid;
      end
    end
  end

  assign stat_o.miss = (lo_q >= hix_q);
  assign stat_o.hit  = (probe_q == key_i);
  assign slot_o      = mid_q;

endmodule

`default_nettype wire

// ===== rtl/core/skbt_ledger.sv =====
// ---------------------------------------------------------------------------
// skbt_ledger
// Balance memory with one shared 49-bit adder used for deposit (add with
// saturation) and withdrawal (subtract with borrow and zero-amount check).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module skbt_ledger #(
  parameter int unsigned MAX_ENTRIES = skbt_pkg::MaxEntries,
  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1),
  localparam int unsigned IdxW = $clog2(MAX_ENTRIES)
) (
  input  wire logic                       clk_i,
  input  wire skbt_pkg::ledg_ctrl_t       ctrl_i,
  input  wire logic [IdxW-1:0]            slot_i,
  input  wire logic [CntW-1:0]            count_i,
  input  wire logic [skbt_pkg::KindW-1:0] kind_i,
  input  wire logic [skbt_pkg::AmtW-1:0]  amount_i,
  output logic [skbt_pkg::AmtW-1:0]       bal_o,
  output logic                            refused_o
);

  localparam int unsigned AmtW = skbt_pkg::AmtW;

  logic [AmtW-1:0] bal_mem [MAX_ENTRIES];
  logic [AmtW-1:0] rdata_q;

  logic            sub;
  logic [AmtW:0]   opnd;
  logic [AmtW:0]   sum;
  logic            wr_en;

  // two's complement subtract: invert and carry in; bit AmtW is carry/borrow
  assign sub  = (kind_i == skbt_pkg::KIND_WITHDRAW);
  assign opnd = sub ? {1'b1, ~amount_i} : {1'b0, amount_i};
  assign sum  = {1'b0, rdata_q} + opnd + (AmtW + 1)'(sub);

  always_comb begin
    refused_o = 1'b0;
    wr_en     = 1'b0;
    case (kind_i)
      skbt_pkg::KIND_DEPOSIT: begin
        bal_o = sum[AmtW] ? {AmtW{1'b1}} : sum[AmtW-1:0];
        wr_en = 1'b1;
      end
      skbt_pkg::KIND_WITHDRAW: begin
        refused_o = (amount_i == '0) || sum[AmtW];
        bal_o     = refused_o ? rdata_q : sum[AmtW-1:0];
        wr_en     = !refused_o;
      end
      skbt_pkg::KIND_QUERY: begin
        bal_o = rdata_q;
      end
      default: begin
        bal_o = rdata_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd) begin
      rdata_q <= bal_mem[slot_i];
    end
    if (ctrl_i.wr_new) begin
      bal_mem[count_i[IdxW-1:0]] <= amount_i;
    end else if (ctrl_i.upd && wr_en) begin
      bal_mem[slot_i] <= bal_o;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sorted_key_balance_table_unit.sv =====
// Sorted key balance table. Add appends a key and starting balance at the
// next free slot, or reports a full table and writes nothing. Deposit,
// withdraw and query run a binary search over the filled slots: each probe
// is a registered read of the key memory, then the compare, and a lookup
// takes at most ceil(log2(n+1)) probes for n entries, 8 for 128. The
// balance update adds one read and one pass through the shared adder.
// Keys must be added in ascending unsigned order for lookups to find them.
// One request is worked on at a time; ready returns as the result is
// registered, and the next request may be accepted while it waits.
// ---------------------------------------------------------------------------
// sorted_key_balance_table_unit
// Top level: request sequencer, key search, balance ledger and result
// register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_balance_table_unit #(
  parameter int unsigned MAX_ENTRIES = skbt_pkg::MaxEntries
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  skbt_req_if.sink  req,
  skbt_rsp_if.source rsp
);

  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IdxW = $clog2(MAX_ENTRIES);
  localparam int unsigned AmtW = skbt_pkg::AmtW;
  localparam int unsigned PosW = skbt_pkg::PosW;

  skbt_pkg::state_e state_q, state_d;

  logic [skbt_pkg::KindW-1:0] kind_q;
  logic [skbt_pkg::KeyW-1:0]  key_q;
  logic [AmtW-1:0]            amount_q;
  logic [CntW-1:0]            count_q;

  skbt_pkg::srch_ctrl_t srch_ctrl;
  skbt_pkg::srch_stat_t srch_stat;
  skbt_pkg::ledg_ctrl_t ledg_ctrl;
  logic [IdxW-1:0]      slot;
  logic [AmtW-1:0]      new_bal;
  logic                 refused;

  logic                       take;
  logic                       cnt_inc;
  logic                       res_load;
  logic                       out_load;
  logic                       table_full;
  logic [skbt_pkg::StatW-1:0] res_status_d, res_status_q;
  logic [PosW-1:0]            res_pos_d, res_pos_q;
  logic [AmtW-1:0]            res_bal_d, res_bal_q;

  logic                       out_valid_q;
  logic [skbt_pkg::StatW-1:0] out_status_q;
  logic [PosW-1:0]            out_pos_q;
  logic [AmtW-1:0]            out_bal_q;

  assign table_full = (count_q == CntW'(MAX_ENTRIES));

  skbt_search #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_search (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (srch_ctrl),
    .count_i (count_q),
    .key_i   (key_q),
    .stat_o  (srch_stat),
    .slot_o  (slot)
  );

  skbt_ledger #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_ledger (
    .clk_i     (clk_i),
    .ctrl_i    (ledg_ctrl),
    .slot_i    (slot),
    .count_i   (count_q),
    .kind_i    (kind_q),
    .amount_i  (amount_q),
    .bal_o     (new_bal),
    .refused_o (refused)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      skbt_pkg::ST_IDLE: begin
        if (req.valid) state_d = skbt_pkg::ST_START;
      end
      skbt_pkg::ST_START: begin
        state_d = (kind_q == skbt_pkg::KIND_ADD) ? skbt_pkg::ST_DONE : skbt_pkg::ST_PROBE;
      end
      skbt_pkg::ST_PROBE: begin
        state_d = srch_stat.miss ? skbt_pkg::ST_DONE : skbt_pkg::ST_CMP;
      end
      skbt_pkg::ST_CMP: begin
        state_d = srch_stat.hit ? skbt_pkg::ST_BAL : skbt_pkg::ST_PROBE;
      end
      skbt_pkg::ST_BAL: begin
        state_d = skbt_pkg::ST_DONE;
      end
      skbt_pkg::ST_DONE: begin
        if (!out_valid_q || rsp.ready) state_d = skbt_pkg::ST_IDLE;
      end
      default: begin
        state_d = skbt_pkg::ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    req.ready    = 1'b0;
    take         = 1'b0;
    cnt_inc      = 1'b0;
    res_load     = 1'b0;
    out_load     = 1'b0;
    srch_ctrl    = '0;
    ledg_ctrl    = '0;
    res_status_d = skbt_pkg::STAT_OK;
    res_pos_d    = '0;
    res_bal_d    = '0;
    case (state_q)
      skbt_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        take      = req.valid;
      end
      skbt_pkg::ST_START: begin
        if (kind_q == skbt_pkg::KIND_ADD) begin
          res_load = 1'b1;
          if (table_full) begin
            res_status_d = skbt_pkg::STAT_FULL;
          end else begin
            srch_ctrl.wr     = 1'b1;
            ledg_ctrl.wr_new = 1'b1;
            cnt_inc          = 1'b1;
            res_pos_d        = PosW'(count_q);
            res_bal_d        = amount_q;
          end
        end else begin
          srch_ctrl.init = 1'b1;
        end
      end
      skbt_pkg::ST_PROBE: begin
        if (srch_stat.miss) begin
          res_load     = 1'b1;
          res_status_d = skbt_pkg::STAT_NOT_FOUND;
        end else begin
          srch_ctrl.rd = 1'b1;
        end
      end
      skbt_pkg::ST_CMP: begin
        if (srch_stat.hit) begin
          ledg_ctrl.rd = 1'b1;
        end else begin
          srch_ctrl.cmp = 1'b1;
        end
      end
      skbt_pkg::ST_BAL: begin
        ledg_ctrl.upd = 1'b1;
        res_load      = 1'b1;
        res_status_d  = refused ? skbt_pkg::STAT_REFUSED : skbt_pkg::STAT_OK;
        res_pos_d     = PosW'(slot);
        res_bal_d     = new_bal;
      end
      skbt_pkg::ST_DONE: begin
        out_load = !out_valid_q || rsp.ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= skbt_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cnt_inc) begin
        count_q <= count_q + CntW'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      kind_q   <= req.kind;
      key_q    <= req.key;
      amount_q <= req.amount;
    end
    if (res_load) begin
      res_status_q <= res_status_d;
      res_pos_q    <= res_pos_d;
      res_bal_q    <= res_bal_d;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_pos_q    <= res_pos_q;
      out_bal_q    <= res_bal_q;
    end
  end

  assign rsp.valid    = out_valid_q;
  assign rsp.status   = out_status_q;
  assign rsp.position = out_pos_q;
  assign rsp.balance  = out_bal_q;

endmodule

`default_nettype wire

// ===== rtl/core/skbt_checker.sv =====
// ---------------------------------------------------------------------------
// skbt_checker
// Port-level checks of the sorted key balance table, bound to the top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module skbt_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        req_valid_i,
  input wire logic                        req_ready_i,
  input wire logic                        rsp_valid_i,
  input wire logic                        rsp_ready_i,
  input wire logic [skbt_pkg::StatW-1:0]  rsp_status_i,
  input wire logic [skbt_pkg::PosW-1:0]   rsp_position_i,
  input wire logic [skbt_pkg::AmtW-1:0]   rsp_balance_i
);

  // one request at a time: ready drops right after a request is taken
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("ready held after request accepted");

  // a new result appears only as the sequencer returns to idle
  a_result_with_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> req_ready_i)
    else $error("result raised while still busy");

  // full table and missing key report slot and balance zero
  a_fail_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == skbt_pkg::STAT_FULL ||
                    rsp_status_i == skbt_pkg::STAT_NOT_FOUND)
    |-> rsp_position_i == '0 && rsp_balance_i == '0)
    else $error("nonzero slot or balance on failed request");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      $stable(rsp_status_i) && $stable(rsp_position_i) && $stable(rsp_balance_i))
    else $error("result payload changed while stalled");

endmodule

bind sorted_key_balance_table_unit skbt_checker u_skbt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req.valid),
  .req_ready_i    (req.ready),
  .rsp_valid_i    (rsp.valid),
  .rsp_ready_i    (rsp.ready),
  .rsp_status_i   (rsp.status),
  .rsp_position_i (rsp.position),
  .rsp_balance_i  (rsp.balance)
);

`default_nettype wire
